### rtl/lob_pkg.sv
// Shared types, constants and helpers for the layer alpha over blend unit.
// No dependencies.
package lob_pkg;

  localparam int unsigned ChanW   = 8;             // color and alpha width
  localparam int unsigned WeightW = 2 * ChanW;     // au*255 or (255-au)*ab
  localparam int unsigned NumW    = ChanW + WeightW; // weighted sum numerator
  localparam int unsigned DenW    = WeightW;       // combined weight D
  localparam int unsigned QuoW    = ChanW;         // quotient bits, one per stage
  localparam int unsigned PreStages = 2;           // weights, then numerators
  localparam int unsigned Latency   = PreStages + QuoW;

  localparam logic [ChanW-1:0] ChanMax = '1;

  typedef struct packed {
    logic [ChanW-1:0] acc_red;
    logic [ChanW-1:0] acc_green;
    logic [ChanW-1:0] acc_blue;
    logic [ChanW-1:0] acc_alpha;
    logic [ChanW-1:0] layer_red;
    logic [ChanW-1:0] layer_green;
    logic [ChanW-1:0] layer_blue;
    logic [ChanW-1:0] layer_alpha;
    logic             layer_visible;
  } lob_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
  } lob_out_t;

  // floor(d / 255), exact for d up to 65279 (quotient fits in 8 bits)
  function automatic logic [ChanW-1:0] div255(input logic [DenW-1:0] d);
    logic [DenW:0] t;
    t = {1'b0, d} + {{(ChanW+1){1'b0}}, d[DenW-1:ChanW]} + {{DenW{1'b0}}, 1'b1};
    return t[DenW-1:ChanW];
  endfunction

endpackage

### rtl/layer_alpha_over_blend_unit.sv
// Top level of the layer alpha over blend unit: weight and numerator stages
// followed by three pipelined dividers. Depends on lob_pkg and lob_div.
//
// Usage:
//   Input channel: drive pix_i with the accumulated pixel and the layer
//   pixel and raise start for one cycle per word. busy is always low, so a
//   word is taken at every edge where start is high: one word per cycle.
//   Output channel: out_valid_o marks the single cycle in which res_o holds
//   a result word; there is no back pressure, the receiver must take it.
//   Pipeline: one weight stage, one numerator stage, then one stage per
//   quotient bit of the 8-bit restoring dividers.
//   Throughput: one word per cycle, set by the per-bit divider stages,
//   each a single 24-bit compare and subtract.
//   Reset (rst_ni low, asynchronous): clears the valid pipe, so words in
//   flight are dropped and no strobe fires until new words come through.
//   Invisible layer or opaque accumulated pixel: the divider is fed with a
//   unit denominator so the accumulated color comes through unchanged.
//   Zero combined weight yields an all-zero word.
module layer_alpha_over_blend_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  lob_pkg::lob_in_t pix_i,
  output logic             out_valid_o,
  output lob_pkg::lob_out_t res_o
);

  localparam int unsigned CW = lob_pkg::ChanW;
  localparam int unsigned WW = lob_pkg::WeightW;
  localparam int unsigned NW = lob_pkg::NumW;
  localparam int unsigned DW = lob_pkg::DenW;
  localparam int unsigned QW = lob_pkg::QuoW;

  // fully pipelined, never stalls the sender
  assign busy = 1'b0;

  // valid bits, one per stage
  logic [lob_pkg::Latency-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[lob_pkg::Latency-2:0], start};
    end
  end

  // ---- stage 1: layer weights ----
  logic          byp_d;
  logic [WW-1:0] wa_d, wb_d;
  logic          byp_q;
  logic [WW-1:0] wa_q, wb_q;
  logic [CW-1:0] au_q;
  logic [CW-1:0] acc_q [3];
  logic [CW-1:0] lay_q [3];

  always_comb begin
    byp_d = !pix_i.layer_visible || (pix_i.acc_alpha == lob_pkg::ChanMax);
    if (byp_d) begin
      // unit weight on the accumulated pixel: num = acc, den = 1
      wa_d = WW'(1);
      wb_d = '0;
    end else begin
      wa_d = {pix_i.acc_alpha, {CW{1'b0}}} - WW'(pix_i.acc_alpha);
      wb_d = WW'(lob_pkg::ChanMax - pix_i.acc_alpha) * WW'(pix_i.layer_alpha);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_q    <= byp_d;
    wa_q     <= wa_d;
    wb_q     <= wb_d;
    au_q     <= pix_i.acc_alpha;
    acc_q[0] <= pix_i.acc_red;
    acc_q[1] <= pix_i.acc_green;
    acc_q[2] <= pix_i.acc_blue;
    lay_q[0] <= pix_i.layer_red;
    lay_q[1] <= pix_i.layer_green;
    lay_q[2] <= pix_i.layer_blue;
  end

  // ---- stage 2: numerators, denominator, alpha ----
  logic [DW-1:0] d_sum;
  logic [NW-1:0] num_d [3];
  logic [NW-1:0] num_q [3];
  logic [DW-1:0] den_q;
  logic [CW-1:0] alpha_q [QW+1];

  assign d_sum = wa_q + wb_q;   // at most 65025, no carry out

  for (genvar c = 0; c < 3; c++) begin : g_num
    assign num_d[c] = (NW'(acc_q[c]) * NW'(wa_q)) + (NW'(lay_q[c]) * NW'(wb_q));
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      num_q[c] <= num_d[c];
    end
    // both alphas zero: numerators are zero too, a unit den gives zeros
    den_q      <= (d_sum == '0) ? DW'(1) : d_sum;
    alpha_q[0] <= byp_q ? au_q : lob_pkg::div255(d_sum);
    // alpha rides alongside the dividers
    for (int s = 1; s <= QW; s++) begin
      alpha_q[s] <= alpha_q[s-1];
    end
  end

  // ---- stages 3..10: dividers ----
  logic [QW-1:0] quo [3];

  for (genvar c = 0; c < 3; c++) begin : g_div
    lob_div u_div (
      .clk_i (clk_i),
      .num_i (num_q[c]),
      .den_i (den_q),
      .quo_o (quo[c])
    );
  end

  assign out_valid_o     = vld_q[lob_pkg::Latency-1];
  assign res_o.out_red   = quo[0];
  assign res_o.out_green = quo[1];
  assign res_o.out_blue  = quo[2];
  assign res_o.out_alpha = alpha_q[QW];

`ifndef SYNTH
  // every accepted word yields a strobe after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##(lob_pkg::Latency) out_valid_o)
    else $error("result strobe missing after accepted word");

  // the divider never sees a zero denominator
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> den_q != '0)
    else $error("zero denominator entered divider");

  // quotients fit in 8 bits
  a_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (num_q[0] < {den_q, {QW{1'b0}}}) && (num_q[1] < {den_q, {QW{1'b0}}})
                 && (num_q[2] < {den_q, {QW{1'b0}}}))
    else $error("numerator out of divider range");

  // pass-through keeps the accumulated alpha
  a_byp_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && byp_q |=> alpha_q[0] == $past(au_q))
    else $error("pass-through alpha altered");
`endif

endmodule

### rtl/lob_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on lob_pkg. Requires num_i < den_i * 2^QuoW and den_i != 0.
module lob_div (
  input  logic                     clk_i,
  input  logic [lob_pkg::NumW-1:0] num_i,
  input  logic [lob_pkg::DenW-1:0] den_i,
  output logic [lob_pkg::QuoW-1:0] quo_o
);

  logic [lob_pkg::NumW-1:0] rem_q [lob_pkg::QuoW];
  logic [lob_pkg::DenW-1:0] den_q [lob_pkg::QuoW];
  logic [lob_pkg::QuoW-1:0] quo_q [lob_pkg::QuoW];

  for (genvar s = 0; s < lob_pkg::QuoW; s++) begin : g_stage
    localparam int unsigned Bit = lob_pkg::QuoW - 1 - s;

    logic [lob_pkg::NumW-1:0] rem_in;
    logic [lob_pkg::DenW-1:0] den_in;
    logic [lob_pkg::QuoW-1:0] quo_in;
    logic [lob_pkg::NumW-1:0] shifted;
    logic                     fits;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign shifted = lob_pkg::NumW'(den_in) << Bit;
    assign fits    = rem_in >= shifted;

    always_ff @(posedge clk_i) begin
      rem_q[s] <= fits ? rem_in - shifted : rem_in;
      den_q[s] <= den_in;
      quo_q[s] <= quo_in | (lob_pkg::QuoW'(fits) << Bit);
    end
  end

  assign quo_o = quo_q[lob_pkg::QuoW-1];

endmodule
